// ===== rtl/ktl_pkg.sv =====
// ============================================================================
// ktl_pkg
// Token kinds, error codes, keyword text and the result item type shared by
// the keyword token lexer.
// ============================================================================
`timescale 1ns / 1ps

package ktl_pkg;

    localparam int STORE_SLOTS = 8;
    localparam int NUM_KW      = 10;

    // Token kinds
    localparam logic [4:0] KIND_OPEN     = 5'd0;
    localparam logic [4:0] KIND_CLOSE    = 5'd1;
    localparam logic [4:0] KIND_KEYWORD0 = 5'd2;
    localparam logic [4:0] KIND_OP0      = 5'd12;
    localparam logic [4:0] KIND_NUMBER   = 5'd19;
    localparam logic [4:0] KIND_IDENT    = 5'd20;
    localparam logic [4:0] KIND_ERROR    = 5'd21;

    // Error codes
    localparam logic [1:0] ERR_NONE   = 2'd0;
    localparam logic [1:0] ERR_EOL    = 2'd1;
    localparam logic [1:0] ERR_NUMBER = 2'd2;

    // Character codes
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_OPEN  = 8'h28;
    localparam logic [7:0] CH_CLOSE = 8'h29;
    localparam logic [7:0] CH_MINUS = 8'h2D;

    // Operator index, OP_NONE when the byte is no operator
    localparam logic [2:0] OP_NONE = 3'd7;

    // Keywords, first character in the low byte, zero padded
    localparam logic [63:0] KW_TEXT [NUM_KW] = '{
        64'h0000_0000_7469_7571,   // quit
        64'h0000_0000_706C_6568,   // help
        64'h0000_0000_706D_7564,   // dump
        64'h0000_0000_7473_696C,   // list
        64'h0000_656E_6966_6564,   // define
        64'h0000_0000_6C61_7665,   // eval
        64'h0000_0000_0000_6669,   // if
        64'h0000_0065_6C69_6877,   // while
        64'h0000_0000_0074_6573,   // set
        64'h0000_006E_6967_6562    // begin
    };

    typedef struct packed {
        logic [4:0]         kind;
        logic signed [27:0] number;
        logic [63:0]        text;
        logic [3:0]         text_length;
        logic [1:0]         error_code;
        logic               last;
    } result_t;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic is_alnum(input logic [7:0] c);
        return is_digit(c) || ((c >= 8'h61) && (c <= 8'h7A))
            || ((c >= 8'h41) && (c <= 8'h5A));
    endfunction

    function automatic logic [2:0] op_index(input logic [7:0] c);
        logic [2:0] idx;
        unique case (c)
            8'h2B:   idx = 3'd0;   // +
            8'h2D:   idx = 3'd1;   // -
            8'h2A:   idx = 3'd2;   // *
            8'h2F:   idx = 3'd3;   // /
            8'h3D:   idx = 3'd4;   // =
            8'h3C:   idx = 3'd5;   // <
            8'h3E:   idx = 3'd6;   // >
            default: idx = OP_NONE;
        endcase
        return idx;
    endfunction

endpackage

// ===== rtl/keyword_token_lexer_core.sv =====
// ============================================================================
// keyword_token_lexer_core
// Streaming tokenizer: one character byte per item in, token items out.
//
// Takes one character per accepted item and emits tokens: ten keywords,
// seven single-character operators, signed decimal numbers, identifiers,
// parentheses, a malformed-number error and an end-of-line error on NUL.
// A word is emitted when the character that ends it arrives; a parenthesis
// or NUL that ends a word gives two items, the word (last = 0) and then its
// own token (last = 1). Words keep their first MAX_WORD characters. Each
// character is handled in the cycle it is accepted: the word store and the
// classifier feed a four-entry result queue, so one character per cycle is
// sustained while the output side keeps up. in_ready drops while more than
// two results are queued. Results pass through the result queue registers
// before they appear at the output.
// ============================================================================
`timescale 1ns / 1ps

module keyword_token_lexer_core #(
    parameter int MAX_WORD = 8
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [7:0]           ch,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [4:0]           kind,
    output logic signed [27:0]   number,
    output logic [63:0]          text,
    output logic [3:0]           text_length,
    output logic [1:0]           error_code,
    output logic                 last
);
    import ktl_pkg::*;

    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // ------------------------------------------------------------------
    // Word state
    // ------------------------------------------------------------------
    logic        in_word_reg, in_word_next;
    logic [63:0] word_text_reg, word_text_next;   // bytes past count undefined
    logic [3:0]  word_count_reg, word_count_next;
    logic        digits_only_reg, digits_only_next;
    logic [26:0] value_reg, value_next;

    // Result queue
    result_t             q_reg [QDEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0]   count_reg;

    logic in_fire, out_fire;
    logic single, op_char, word_char;
    logic start, store_any, emit_word;
    logic [1:0] n_push;

    logic [3:0]  st_count;
    logic        st_digits;
    logic [26:0] st_value;
    logic [26:0] value_x10;

    result_t word_res, single_res, push0, push1;
    logic [63:0] masked_text;
    logic [7:0]  first_ch;
    logic [2:0]  first_op;

    assign in_ready  = (count_reg <= QCNT_W'(QDEPTH - 2));
    assign in_fire   = in_valid && in_ready;
    assign out_valid = (count_reg != '0);
    assign out_fire  = out_valid && out_ready;

    // ------------------------------------------------------------------
    // Character classes
    // ------------------------------------------------------------------
    assign single    = (ch == CH_NUL) || (ch == CH_OPEN) || (ch == CH_CLOSE);
    assign op_char   = (op_index(ch) != OP_NONE);
    assign word_char = is_alnum(ch);

    // Pending word ends on anything but a word character
    assign emit_word = in_word_reg && !word_char;
    // An operator always opens a new word; a word character opens one
    // only when none is pending.
    assign start     = (!in_word_reg && (op_char || word_char)) || (in_word_reg && op_char);
    assign store_any = start || (in_word_reg && word_char);
    assign n_push    = {1'b0, emit_word} + {1'b0, single};

    // ------------------------------------------------------------------
    // Store one character into the pending (or fresh) word
    // ------------------------------------------------------------------
    assign st_count  = start ? 4'd0  : word_count_reg;
    assign st_digits = start ? 1'b1  : digits_only_reg;
    assign st_value  = start ? 27'd0 : value_reg;
    assign value_x10 = (st_value << 3) + (st_value << 1) + 27'(ch - 8'h30);

    always_comb
    begin
        in_word_next     = in_word_reg;
        word_text_next   = word_text_reg;
        word_count_next  = word_count_reg;
        digits_only_next = digits_only_reg;
        value_next       = value_reg;
        if (in_fire) begin
            in_word_next = store_any;
            if (store_any) begin
                word_count_next  = st_count;
                digits_only_next = st_digits;
                value_next       = st_value;
                if (st_count < 4'(MAX_WORD)) begin
                    word_text_next[st_count[2:0]*8 +: 8] = ch;
                    word_count_next = st_count + 4'd1;
                    if (is_digit(ch)) begin
                        if (st_digits) begin
                            value_next = value_x10;
                        end
                    end else if (!((st_count == 4'd0) && (ch == CH_MINUS))) begin
                        digits_only_next = 1'b0;
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Classify the pending word
    // ------------------------------------------------------------------
    always_comb
    begin
        for (int i = 0; i < STORE_SLOTS; i++) begin
            masked_text[i*8 +: 8] = (4'(i) < word_count_reg) ? word_text_reg[i*8 +: 8] : 8'h00;
        end
    end

    assign first_ch = masked_text[7:0];
    assign first_op = op_index(first_ch);

    always_comb
    begin
        word_res             = '0;
        word_res.text        = masked_text;
        word_res.text_length = word_count_reg;
        word_res.kind        = KIND_IDENT;
        // Stored characters are never NUL, so a zero-padded match is exact
        for (int k = NUM_KW - 1; k >= 0; k--) begin
            if ((word_count_reg != 4'd0) && (masked_text == KW_TEXT[k])) begin
                word_res.kind = KIND_KEYWORD0 + 5'(k);
            end
        end
        if (word_res.kind == KIND_IDENT && word_count_reg != 4'd0) begin
            priority if ((word_count_reg == 4'd1) && (first_op != OP_NONE)) begin
                word_res.kind = KIND_OP0 + {2'b00, first_op};
            end else if (is_digit(first_ch) || (first_ch == CH_MINUS)) begin
                if (digits_only_reg) begin
                    word_res.kind   = KIND_NUMBER;
                    word_res.number = (first_ch == CH_MINUS) ? -$signed({1'b0, value_reg})
                                                              :  $signed({1'b0, value_reg});
                end else begin
                    word_res.kind       = KIND_ERROR;
                    word_res.error_code = ERR_NUMBER;
                end
            end else begin
                word_res.kind = KIND_IDENT;
            end
        end
    end

    // Parenthesis or end of line
    always_comb
    begin
        single_res = '0;
        if (ch == CH_NUL) begin
            single_res.kind       = KIND_ERROR;
            single_res.error_code = ERR_EOL;
        end else begin
            single_res.kind        = (ch == CH_OPEN) ? KIND_OPEN : KIND_CLOSE;
            single_res.text        = {56'd0, ch};
            single_res.text_length = 4'd1;
        end
    end

    // Items to push: word first when there is one, then the single token
    always_comb
    begin
        push0      = emit_word ? word_res : single_res;
        push0.last = (n_push == 2'd1);
        push1      = single_res;
        push1.last = 1'b1;
    end

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_word_reg     <= 1'b0;
            word_count_reg  <= 4'd0;
            digits_only_reg <= 1'b1;
            value_reg       <= 27'd0;
            wr_ptr_reg      <= '0;
            rd_ptr_reg      <= '0;
            count_reg       <= '0;
        end else begin
            in_word_reg     <= in_word_next;
            word_count_reg  <= word_count_next;
            digits_only_reg <= digits_only_next;
            value_reg       <= value_next;
            if (in_fire) begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(n_push);
            end
            if (out_fire) begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
            count_reg <= count_reg + QCNT_W'(in_fire ? n_push : 2'd0)
                       - QCNT_W'(out_fire);
        end
    end

    // Payload: no reset
    always_ff @(posedge clk)
    begin
        word_text_reg <= word_text_next;
        if (in_fire && (n_push != 2'd0)) begin
            q_reg[wr_ptr_reg] <= push0;
            if (n_push == 2'd2) begin
                q_reg[wr_ptr_reg + QPTR_W'(1)] <= push1;
            end
        end
    end

    assign kind        = q_reg[rd_ptr_reg].kind;
    assign number      = q_reg[rd_ptr_reg].number;
    assign text        = q_reg[rd_ptr_reg].text;
    assign text_length = q_reg[rd_ptr_reg].text_length;
    assign error_code  = q_reg[rd_ptr_reg].error_code;
    assign last        = q_reg[rd_ptr_reg].last;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QCNT_W'(QDEPTH))
        else $error("result queue overflow");

    a_word_bound: assert property (@(posedge clk) disable iff (!rst_n)
        word_count_reg <= 4'(MAX_WORD))
        else $error("word count past MAX_WORD");

    a_word_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        in_word_reg |-> (word_count_reg != 4'd0))
        else $error("pending word with no characters");

    a_eol_closes: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && (ch == CH_NUL)) |=> (!in_word_reg && (count_reg != '0)))
        else $error("end of line left a word pending or queued nothing");

    a_number_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (kind != KIND_NUMBER)) |-> (number == 28'sd0))
        else $error("nonzero number on non-number item");

endmodule
